// ===== sv/mhtk_pkg.sv =====
// Shared types and constants for the min-heap top-k selector.
package mhtk_pkg;

   // Store geometry and field widths.
   localparam int DEPTH      = 1024;
   localparam int COORD_BITS = 12;
   localparam int KEY_BITS   = 8;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int CHILD_BITS = ADDR_BITS + 2;
   localparam int INDEX_BITS = 10;
   localparam int CMD_BITS   = 3;
   localparam int STAT_BITS  = 2;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_APPEND  = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_BUILD   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_REPLACE = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_READ    = 3'd4;

   // Status codes.
   localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd3;

   // One input item.
   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic [KEY_BITS-1:0]   value;
      logic [INDEX_BITS-1:0] index;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [COORD_BITS-1:0] read_row;
      logic [COORD_BITS-1:0] read_col;
      logic [KEY_BITS-1:0]   read_value;
      logic [KEY_BITS-1:0]   root_value;
      logic [CNT_BITS-1:0]   count;
      logic [STAT_BITS-1:0]  status;
   } rsp_type;

   // One stored heap entry.
   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic [KEY_BITS-1:0]   key;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic dispatch;      // latch status of the held item, clear read fields
      logic clear_count;   // empty the store
      logic append;        // write item entry at the end, bump count
      logic build_init;    // parent counter takes count / 2
      logic p_step;        // step to the next parent down and read it
      logic load_cur;      // sifted entry takes the read data
      logic replace_init;  // sifted entry takes the item entry, position zero
      logic read_issue;    // read the entry at the item index
      logic capture_read;  // read fields take the read data
      logic read_left;     // read the left child
      logic take_left;     // hold the left child
      logic read_right;    // read the right child
      logic move_child;    // move the smaller child up, follow it down
      logic write_cur;     // place the sifted entry at its position
      logic finish;        // register the result and strobe it
   } dp_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_BITS-1:0]  cmd;
      logic [STAT_BITS-1:0] status;
      logic                 count_ge2;
      logic                 p_zero;
      logic                 lc_ok;
      logic                 rc_ok;
      logic                 pick_any;
   } dp_stat_type;

endpackage

// ===== sv/mhtk_ctrl.sv =====
// Controller state machine sequencing commands, heap build and sift-down.
module mhtk_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  mhtk_pkg::dp_stat_type st,
   output mhtk_pkg::dp_ctl_type  ctl,
   output logic                 busy
);
   import mhtk_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DISPATCH = 10'b00_0000_0010,
      S_BLD_NEXT = 10'b00_0000_0100,
      S_BLD_LOAD = 10'b00_0000_1000,
      S_SD_LC    = 10'b00_0001_0000,
      S_SD_LW    = 10'b00_0010_0000,
      S_SD_CMP   = 10'b00_0100_0000,
      S_SD_DONE  = 10'b00_1000_0000,
      S_RD_WAIT  = 10'b01_0000_0000,
      S_RESP     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ctl.dispatch = 1'b1;
            state_in     = S_RESP;
            case (st.cmd)
               CMD_CLEAR: begin
                  ctl.clear_count = 1'b1;
               end
               CMD_APPEND: begin
                  ctl.append = (st.status == ST_OK);
               end
               CMD_BUILD: begin
                  if (st.count_ge2) begin
                     ctl.build_init = 1'b1;
                     state_in       = S_BLD_NEXT;
                  end
               end
               CMD_REPLACE: begin
                  if (st.status == ST_OK) begin
                     ctl.replace_init = 1'b1;
                     state_in         = S_SD_LC;
                  end
               end
               CMD_READ: begin
                  if (st.status == ST_OK) begin
                     ctl.read_issue = 1'b1;
                     state_in       = S_RD_WAIT;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_BLD_NEXT: begin
            if (st.p_zero) begin
               state_in = S_RESP;
            end else begin
               ctl.p_step = 1'b1;
               state_in   = S_BLD_LOAD;
            end
         end
         S_BLD_LOAD: begin
            ctl.load_cur = 1'b1;
            state_in     = S_SD_LC;
         end
         S_SD_LC: begin
            if (st.lc_ok) begin
               ctl.read_left = 1'b1;
               state_in      = S_SD_LW;
            end else begin
               state_in = S_SD_DONE;
            end
         end
         S_SD_LW: begin
            ctl.take_left  = 1'b1;
            ctl.read_right = st.rc_ok;
            state_in       = S_SD_CMP;
         end
         S_SD_CMP: begin
            if (st.pick_any) begin
               ctl.move_child = 1'b1;
               state_in       = S_SD_LC;
            end else begin
               state_in = S_SD_DONE;
            end
         end
         S_SD_DONE: begin
            ctl.write_cur = 1'b1;
            state_in      = (st.cmd == CMD_BUILD) ? S_BLD_NEXT : S_RESP;
         end
         S_RD_WAIT: begin
            ctl.capture_read = 1'b1;
            state_in         = S_RESP;
         end
         S_RESP: begin
            ctl.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== sv/mhtk_dpath.sv =====
// Datapath with the entry store, count, sift-down registers and result register.
module mhtk_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  mhtk_pkg::req_type     req_item,
   input  mhtk_pkg::dp_ctl_type  ctl,
   output mhtk_pkg::dp_stat_type st,
   output logic                  rsp_strobe,
   output mhtk_pkg::rsp_type     rsp_item
);
   import mhtk_pkg::*;

   entry_type mem [DEPTH];

   req_type               req_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   p_ff;
   logic [ADDR_BITS-1:0]  pos_ff;
   entry_type             cur_ff;
   entry_type             left_ff;
   entry_type             rdata_ff;
   logic [KEY_BITS-1:0]   root_key_ff;
   logic [STAT_BITS-1:0]  status_ff;
   entry_type             rd_fields_ff;
   rsp_type               rsp_ff;
   logic                  strobe_ff;

   logic [STAT_BITS-1:0]  status_in;
   logic [CHILD_BITS-1:0] lc, rc, n_ext;
   logic [CNT_BITS-1:0]   p_dec;
   logic                  left_less, right_less;
   logic [KEY_BITS-1:0]   pick_key;
   entry_type             req_entry;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
   entry_type             wr_data;

   assign req_entry = '{row: req_ff.row, col: req_ff.col, key: req_ff.value};

   // Status of the held item against the current count.
   always_comb begin
      status_in = ST_OK;
      case (req_ff.cmd)
         CMD_APPEND: begin
            if (count_ff >= CNT_BITS'(DEPTH)) status_in = ST_FULL;
         end
         CMD_REPLACE: begin
            if (count_ff == '0) status_in = ST_EMPTY;
         end
         CMD_READ: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (CNT_BITS'(req_ff.index) >= count_ff) begin
               status_in = ST_RANGE;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Child positions and the smaller-child choice, left checked first.
   assign n_ext      = CHILD_BITS'(count_ff);
   assign lc         = CHILD_BITS'({pos_ff, 1'b1});
   assign rc         = lc + CHILD_BITS'(1);
   assign p_dec      = p_ff - CNT_BITS'(1);
   assign left_less  = (left_ff.key < cur_ff.key);
   assign pick_key   = left_less ? left_ff.key : cur_ff.key;
   assign right_less = (rc < n_ext) && (rdata_ff.key < pick_key);

   assign st.cmd       = req_ff.cmd;
   assign st.status    = status_in;
   assign st.count_ge2 = (count_ff >= CNT_BITS'(2));
   assign st.p_zero    = (p_ff == '0);
   assign st.lc_ok     = (lc < n_ext);
   assign st.rc_ok     = (rc < n_ext);
   assign st.pick_any  = left_less || right_less;

   // Read address selection.
   always_comb begin
      rd_addr = pos_ff;
      if (ctl.read_issue) begin
         rd_addr = req_ff.index[ADDR_BITS-1:0];
      end else if (ctl.p_step) begin
         rd_addr = p_dec[ADDR_BITS-1:0];
      end else if (ctl.read_left) begin
         rd_addr = lc[ADDR_BITS-1:0];
      end else if (ctl.read_right) begin
         rd_addr = rc[ADDR_BITS-1:0];
      end
   end

   // Write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      if (ctl.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[ADDR_BITS-1:0];
         wr_data = req_entry;
      end else if (ctl.move_child) begin
         wr_en   = 1'b1;
         wr_data = right_less ? rdata_ff : left_ff;
      end else if (ctl.write_cur) begin
         wr_en = 1'b1;
      end
   end

   // Entry store with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (ctl.dispatch) begin
         status_ff    <= status_in;
         rd_fields_ff <= '0;
      end
      if (ctl.capture_read) begin
         rd_fields_ff <= rdata_ff;
      end
      if (wr_en && (wr_addr == '0)) begin
         root_key_ff <= wr_data.key;
      end
      if (ctl.build_init) begin
         p_ff <= count_ff >> 1;
      end else if (ctl.p_step) begin
         p_ff <= p_dec;
      end
      if (ctl.replace_init) begin
         cur_ff <= req_entry;
         pos_ff <= '0;
      end else if (ctl.load_cur) begin
         cur_ff <= rdata_ff;
      end else if (ctl.p_step) begin
         pos_ff <= p_dec[ADDR_BITS-1:0];
      end else if (ctl.move_child) begin
         pos_ff <= right_less ? rc[ADDR_BITS-1:0] : lc[ADDR_BITS-1:0];
      end
      if (ctl.take_left) begin
         left_ff <= rdata_ff;
      end
      if (ctl.finish) begin
         rsp_ff.read_row   <= rd_fields_ff.row;
         rsp_ff.read_col   <= rd_fields_ff.col;
         rsp_ff.read_value <= rd_fields_ff.key;
         rsp_ff.root_value <= (count_ff != '0) ? root_key_ff : '0;
         rsp_ff.count      <= count_ff;
         rsp_ff.status     <= status_ff;
      end
   end

   // Entry count and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.finish;
         if (ctl.clear_count) begin
            count_ff <= '0;
         end else if (ctl.append) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== sv/min_heap_top_k_selector_top.sv =====
// Top level of the min-heap top-k selector: controller plus datapath.
//
// A command item is taken at a rising edge where start is high and busy is
// low; busy then stays high until the command is done. Each item gives one
// result, shown on rsp_item for exactly one cycle with rsp_strobe high; the
// receiver cannot hold results off, and none is needed since one item is
// worked on at a time.
// Clear, append, read and unused codes need no sift-down. Replace sifts the
// new root entry down one heap level at a time (at most log2 of the store
// depth levels), reading the left and right child at each level through the
// single store read port. Build runs that same sift-down for every parent
// from count / 2 - 1 down to the root. A new item may be taken in the cycle
// the strobe shows.
// Reset empties the store (count zero) and returns the controller to idle;
// the store contents are not cleared, and only positions below the count
// are ever read.
module min_heap_top_k_selector_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mhtk_pkg::req_type req_item,
   output logic              rsp_strobe,
   output mhtk_pkg::rsp_type rsp_item
);
   import mhtk_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type st;
   logic        accept;

   assign accept = start && !busy;

   // Command sequencing.
   mhtk_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .st     (st),
      .ctl    (ctl),
      .busy   (busy)
   );

   // Store and working registers.
   mhtk_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_item   (req_item),
      .ctl        (ctl),
      .st         (st),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
